// File: sv/pidsat_pkg.sv
// Types and constants shared by the saturating PID controller modules.
package pidsat_pkg;

   typedef struct packed {
      logic signed [31:0] target;
      logic signed [31:0] measured;
      logic        [31:0] stamp_us;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic        [1:0]  status;
      logic        [1:0]  clamped;
   } rsp_type;

   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_P     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_I     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_D     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_HIGH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_LOW  = 3'd4;

   localparam logic [1:0] STATUS_COMPUTED = 2'd0;
   localparam logic [1:0] STATUS_FIRST    = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DT  = 2'd2;

   localparam logic [1:0] CLAMP_NONE = 2'd0;
   localparam logic [1:0] CLAMP_HIGH = 2'd1;
   localparam logic [1:0] CLAMP_LOW  = 2'd2;

   localparam logic [31:0] US_PER_SEC = 32'd1000000;

   // each gain term is held within +-2^61
   localparam logic signed [63:0] TERM_MAX = 64'sh2000_0000_0000_0000;
   localparam logic signed [63:0] TERM_MIN = -64'sh2000_0000_0000_0000;

   localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

endpackage

// File: sv/pidsat_mul.sv
// Bit-serial unsigned multiplier: 64-bit multiplicand by 32-bit multiplier, one bit a cycle.
module pidsat_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] mcand,
   input  logic [31:0] mplier,
   output logic        done,
   output logic [95:0] product
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] mcand_ff, mcand_in;
   logic [95:0] acc_ff, acc_in;
   logic [64:0] part;

   always_comb begin
      part     = {1'b0, acc_ff[95:32]} + (acc_ff[0] ? {1'b0, mcand_ff} : 65'd0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = mcand;
         acc_in   = {64'd0, mplier};
      end else if (busy_ff) begin
         // add on the low multiplier bit, then shift right
         acc_in = {part, acc_ff[31:1]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: sv/pidsat_div.sv
// Restoring unsigned divider: 64-bit dividend by nonzero 32-bit divisor, one quotient bit a cycle.
module pidsat_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [32:0] shifted;
   logic [32:0] trial;
   logic        fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      trial   = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // subtract where the divisor fits, else restore
         rem_in = fits ? trial[31:0] : shifted[31:0];
         quo_in = {quo_ff[62:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/pid_controller_saturating_core.sv
// A computed sample runs the full sequence before its result; a skipped one goes straight to it.
// The work is done by one bit-serial multiplier (eight products) and one
// restoring divider (two quotients), used in turn by a sequencer.
// A new sample is taken only once the last one is through; it is taken while the previous result waits.
// Reset (synchronous): gains zero, limits at the full signed range, no sample seen, integral zero.
module pid_controller_saturating_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pidsat_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pidsat_pkg::rsp_type                 rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pidsat_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                         csr_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MINT   = 4'd1;
   localparam logic [3:0] S_DINT   = 4'd2;
   localparam logic [3:0] S_MDER   = 4'd3;
   localparam logic [3:0] S_DDER   = 4'd4;
   localparam logic [3:0] S_THI    = 4'd5;
   localparam logic [3:0] S_TLO    = 4'd6;
   localparam logic [3:0] S_ACC    = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;
   localparam logic [3:0] S_SKIP   = 4'd9;

   localparam logic [1:0] TERM_P = 2'd0;
   localparam logic [1:0] TERM_I = 2'd1;
   localparam logic [1:0] TERM_D = 2'd2;

   logic [3:0]          state_ff, state_in;
   logic                launch_ff, launch_in;
   logic [1:0]          term_ff, term_in;

   logic signed [31:0]  gain_p_ff, gain_i_ff, gain_d_ff, limit_high_ff, limit_low_ff;
   logic signed [32:0]  last_error_ff, last_error_in;
   logic [31:0]         last_stamp_ff, last_stamp_in;
   logic                stamp_seen_ff, stamp_seen_in;
   logic signed [63:0]  error_sum_ff, error_sum_in;

   logic signed [32:0]  e_ff, e_in;
   logic signed [32:0]  prev_ff, prev_in;
   logic [31:0]         dt_ff, dt_in;
   logic [1:0]          status_ff, status_in;
   logic signed [63:0]  integ_ff, integ_in;
   logic [63:0]         dnum_ff, dnum_in;
   logic                dneg_ff, dneg_in;
   logic signed [63:0]  deriv_ff, deriv_in;
   logic                sat_ff, sat_in;
   logic                satneg_ff, satneg_in;
   logic signed [63:0]  ahi_ff, ahi_in;
   logic signed [63:0]  term_val_ff, term_val_in;
   logic signed [63:0]  sum_ff, sum_in;

   logic                rsp_valid_ff, rsp_valid_in;
   pidsat_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                mul_done, div_done;
   logic [95:0]         mul_prod;
   logic [63:0]         div_quo;
   logic [63:0]         mul_a;
   logic [31:0]         mul_b;
   logic [63:0]         div_num;
   logic [31:0]         div_den;

   logic                out_free;
   logic signed [32:0]  e_new;
   logic [32:0]         e_mag;
   logic signed [33:0]  diff;
   logic [33:0]         diff_mag;
   logic signed [31:0]  gain_sel;
   logic [31:0]         gain_mag;
   logic signed [63:0]  value_sel;
   logic signed [47:0]  hi;
   logic [47:0]         hi_mag;
   logic [63:0]         es_mag;

   logic                prod_sat;
   logic signed [63:0]  prod_s;
   logic signed [64:0]  es_sum;
   logic                hi_sat;
   logic signed [63:0]  ahi_mag;
   logic signed [48:0]  lo_s;
   logic signed [63:0]  r_val;
   logic signed [63:0]  lim_hi64, lim_lo64;

   pidsat_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (launch_ff && (state_ff == S_MINT || state_ff == S_MDER ||
                              state_ff == S_THI  || state_ff == S_TLO)),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   pidsat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (launch_ff && (state_ff == S_DINT || state_ff == S_DDER)),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // operand selection
   always_comb begin
      e_mag    = e_ff[32] ? 33'(-e_ff) : 33'(e_ff);
      diff     = 34'(e_ff) - 34'(prev_ff);
      diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
      unique case (term_ff)
         TERM_P: begin
            gain_sel  = gain_p_ff;
            value_sel = 64'(e_ff);
         end
         TERM_I: begin
            gain_sel  = gain_i_ff;
            value_sel = integ_ff;
         end
         TERM_D: begin
            gain_sel  = gain_d_ff;
            value_sel = deriv_ff;
         end
         default: begin
            gain_sel  = '0;
            value_sel = '0;
         end
      endcase
      gain_mag = gain_sel[31] ? 32'(-gain_sel) : 32'(gain_sel);
      hi       = value_sel[63:16];
      hi_mag   = hi[47] ? 48'(-hi) : 48'(hi);
      es_mag   = error_sum_ff[63] ? 64'(-error_sum_ff) : 64'(error_sum_ff);

      mul_a = {64'd0};
      mul_b = gain_mag;
      priority case (state_ff)
         S_MINT: begin
            mul_a = {31'd0, e_mag};
            mul_b = dt_ff;
         end
         S_MDER: begin
            mul_a = {30'd0, diff_mag};
            mul_b = pidsat_pkg::US_PER_SEC;
         end
         S_THI: mul_a = {16'd0, hi_mag};
         S_TLO: mul_a = {48'd0, value_sel[15:0]};
         default: mul_a = {64'd0};
      endcase

      if (state_ff == S_DDER) begin
         div_num = dnum_ff;
         div_den = dt_ff;
      end else begin
         div_num = es_mag;
         div_den = pidsat_pkg::US_PER_SEC;
      end
   end

   // result arithmetic on unit completion
   always_comb begin
      prod_sat = |mul_prod[95:63];
      if (e_ff[32])
         prod_s = prod_sat ? pidsat_pkg::SUM_MIN : 64'(-$signed({1'b0, mul_prod[62:0]}));
      else
         prod_s = prod_sat ? pidsat_pkg::SUM_MAX : $signed({1'b0, mul_prod[62:0]});
      es_sum = 65'(error_sum_ff) + 65'(prod_s);

      hi_sat  = (|mul_prod[95:62]) || (mul_prod[61] && (|mul_prod[60:0]));
      ahi_mag = $signed({2'b00, mul_prod[61:0]});

      lo_s  = gain_sel[31] ? 49'(-$signed({1'b0, mul_prod[47:0]}))
                           : $signed({1'b0, mul_prod[47:0]});
      r_val = ahi_ff + 64'(lo_s >>> 16);

      lim_hi64 = 64'(limit_high_ff);
      lim_lo64 = 64'(limit_low_ff);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign e_new    = 33'(req_data.measured) - 33'(req_data.target);

   always_comb begin
      state_in      = state_ff;
      launch_in     = 1'b0;
      term_in       = term_ff;
      last_error_in = last_error_ff;
      last_stamp_in = last_stamp_ff;
      stamp_seen_in = stamp_seen_ff;
      error_sum_in  = error_sum_ff;
      e_in          = e_ff;
      prev_in       = prev_ff;
      dt_in         = dt_ff;
      status_in     = status_ff;
      integ_in      = integ_ff;
      dnum_in       = dnum_ff;
      dneg_in       = dneg_ff;
      deriv_in      = deriv_ff;
      sat_in        = sat_ff;
      satneg_in     = satneg_ff;
      ahi_in        = ahi_ff;
      term_val_in   = term_val_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               e_in          = e_new;
               prev_in       = last_error_ff;
               dt_in         = req_data.stamp_us - last_stamp_ff;
               last_error_in = e_new;
               last_stamp_in = req_data.stamp_us;
               stamp_seen_in = 1'b1;
               term_in       = TERM_P;
               sum_in        = '0;
               if (!stamp_seen_ff) begin
                  status_in = pidsat_pkg::STATUS_FIRST;
                  state_in  = S_SKIP;
               end else if (req_data.stamp_us == last_stamp_ff) begin
                  status_in = pidsat_pkg::STATUS_ZERO_DT;
                  state_in  = S_SKIP;
               end else begin
                  status_in = pidsat_pkg::STATUS_COMPUTED;
                  state_in  = S_MINT;
                  launch_in = 1'b1;
               end
            end
         end
         S_MINT: begin
            if (mul_done) begin
               // saturating accumulate of e*dt
               if (es_sum > 65'(pidsat_pkg::SUM_MAX))
                  error_sum_in = pidsat_pkg::SUM_MAX;
               else if (es_sum < 65'(pidsat_pkg::SUM_MIN))
                  error_sum_in = pidsat_pkg::SUM_MIN;
               else
                  error_sum_in = es_sum[63:0];
               state_in  = S_DINT;
               launch_in = 1'b1;
            end
         end
         S_DINT: begin
            if (div_done) begin
               integ_in  = error_sum_ff[63] ? -$signed(div_quo) : $signed(div_quo);
               state_in  = S_MDER;
               launch_in = 1'b1;
            end
         end
         S_MDER: begin
            if (mul_done) begin
               dnum_in   = mul_prod[63:0];
               dneg_in   = diff[33];
               state_in  = S_DDER;
               launch_in = 1'b1;
            end
         end
         S_DDER: begin
            if (div_done) begin
               deriv_in  = dneg_ff ? -$signed(div_quo) : $signed(div_quo);
               state_in  = S_THI;
               launch_in = 1'b1;
            end
         end
         S_THI: begin
            if (mul_done) begin
               sat_in    = hi_sat;
               satneg_in = gain_sel[31] ^ hi[47];
               ahi_in    = (gain_sel[31] ^ hi[47]) ? -ahi_mag : ahi_mag;
               state_in  = S_TLO;
               launch_in = 1'b1;
            end
         end
         S_TLO: begin
            if (mul_done) begin
               if (sat_ff)
                  term_val_in = satneg_ff ? pidsat_pkg::TERM_MIN : pidsat_pkg::TERM_MAX;
               else if (r_val > pidsat_pkg::TERM_MAX)
                  term_val_in = pidsat_pkg::TERM_MAX;
               else if (r_val < pidsat_pkg::TERM_MIN)
                  term_val_in = pidsat_pkg::TERM_MIN;
               else
                  term_val_in = r_val;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            sum_in = sum_ff + term_val_ff;
            if (term_ff == TERM_D) begin
               state_in = S_FINISH;
            end else begin
               term_in   = term_ff + 2'd1;
               state_in  = S_THI;
               launch_in = 1'b1;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status_ff;
               if (sum_ff > lim_hi64) begin
                  rsp_data_in.drive   = limit_high_ff;
                  rsp_data_in.clamped = pidsat_pkg::CLAMP_HIGH;
               end else if (sum_ff < lim_lo64) begin
                  rsp_data_in.drive   = limit_low_ff;
                  rsp_data_in.clamped = pidsat_pkg::CLAMP_LOW;
               end else begin
                  rsp_data_in.drive   = sum_ff[31:0];
                  rsp_data_in.clamped = pidsat_pkg::CLAMP_NONE;
               end
               state_in = S_IDLE;
            end
         end
         S_SKIP: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.drive   = '0;
               rsp_data_in.status  = status_ff;
               rsp_data_in.clamped = pidsat_pkg::CLAMP_NONE;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         launch_ff     <= 1'b0;
         term_ff       <= TERM_P;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         limit_high_ff <= 32'sh7FFF_FFFF;
         limit_low_ff  <= 32'sh8000_0000;
         last_error_ff <= '0;
         last_stamp_ff <= '0;
         stamp_seen_ff <= 1'b0;
         error_sum_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         launch_ff     <= launch_in;
         term_ff       <= term_in;
         last_error_ff <= last_error_in;
         last_stamp_ff <= last_stamp_in;
         stamp_seen_ff <= stamp_seen_in;
         error_sum_ff  <= error_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               pidsat_pkg::REG_GAIN_P:     gain_p_ff     <= csr_data;
               pidsat_pkg::REG_GAIN_I:     gain_i_ff     <= csr_data;
               pidsat_pkg::REG_GAIN_D:     gain_d_ff     <= csr_data;
               pidsat_pkg::REG_LIMIT_HIGH: limit_high_ff <= csr_data;
               pidsat_pkg::REG_LIMIT_LOW:  limit_low_ff  <= csr_data;
               default: ;
            endcase
         end
      end
      e_ff        <= e_in;
      prev_ff     <= prev_in;
      dt_ff       <= dt_in;
      status_ff   <= status_in;
      integ_ff    <= integ_in;
      dnum_ff     <= dnum_in;
      dneg_ff     <= dneg_in;
      deriv_ff    <= deriv_in;
      sat_ff      <= sat_in;
      satneg_ff   <= satneg_in;
      ahi_ff      <= ahi_in;
      term_val_ff <= term_val_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sim/pid_controller_saturating_core_test.sv
// Self-checking testbench for the saturating PID controller core.
`timescale 1ns / 100ps

module pid_controller_saturating_core_test;
   import pidsat_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = REG_LIMIT_LOW + 1'b1;
   localparam logic signed [127:0] TERM_LIM = 128'sh2000_0000_0000_0000;
   localparam logic signed [127:0] I64_MAX  = 128'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [127:0] I64_MIN  = -128'sh8000_0000_0000_0000;
   localparam logic signed [127:0] ONE_SEC  = 128'sd1000000;

   class pid_scoreboard;
      logic signed [127:0] gain_p, gain_i, gain_d, lim_hi, lim_lo;
      logic signed [127:0] last_err, err_sum;
      logic [31:0]         last_stamp;
      bit                  seen;
      rsp_type             awaited[$];
      int                  errors;

      function new();
         gain_p = 0; gain_i = 0; gain_d = 0;
         lim_hi = 128'sh7FFF_FFFF; lim_lo = -128'sh8000_0000;
         last_err = 0; err_sum = 0; last_stamp = '0; seen = 0; errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
         logic signed [127:0] v;
         v = $signed(val);
         case (idx)
            REG_GAIN_P:     gain_p = v;
            REG_GAIN_I:     gain_i = v;
            REG_GAIN_D:     gain_d = v;
            REG_LIMIT_HIGH: lim_hi = v;
            REG_LIMIT_LOW:  lim_lo = v;
            default: ;
         endcase
      endfunction

      // gain times value, floor-shifted by 16 and held within +-2^61
      function logic signed [127:0] scale_q16(logic signed [127:0] a, logic signed [127:0] b);
         logic signed [127:0] lo, hi, ua, uh, r;
         if (a == 0) return 0;
         lo = b & 128'sh FFFF;
         hi = (b - lo) >>> 16;
         ua = a < 0 ? -a : a;
         uh = hi < 0 ? -hi : hi;
         if (uh > TERM_LIM / ua) return ((a < 0) != (hi < 0)) ? -TERM_LIM : TERM_LIM;
         r = a * hi + ((a * lo) >>> 16);
         if (r > TERM_LIM) r = TERM_LIM;
         if (r < -TERM_LIM) r = -TERM_LIM;
         return r;
      endfunction

      function void note_sample(req_type r);
         logic signed [127:0] e, dt, prev, prod, integ, deriv, total;
         logic [31:0] d32;
         rsp_type x;
         e = $signed(r.measured);
         e = e - $signed(r.target);
         d32 = r.stamp_us - last_stamp;
         dt = $signed({96'd0, d32});
         prev = last_err;
         last_err = e;
         x.drive = '0; x.clamped = CLAMP_NONE;
         if (!seen) begin
            seen = 1; last_stamp = r.stamp_us; x.status = STATUS_FIRST;
         end else if (d32 == 0) begin
            last_stamp = r.stamp_us; x.status = STATUS_ZERO_DT;
         end else begin
            last_stamp = r.stamp_us; x.status = STATUS_COMPUTED;
            prod = e * dt;
            if (prod > I64_MAX) prod = I64_MAX;
            if (prod < I64_MIN) prod = I64_MIN;
            err_sum = err_sum + prod;
            if (err_sum > I64_MAX) err_sum = I64_MAX;
            if (err_sum < I64_MIN) err_sum = I64_MIN;
            integ = err_sum / ONE_SEC;
            deriv = ((e - prev) * ONE_SEC) / dt;
            total = scale_q16(gain_p, e) + scale_q16(gain_i, integ)
                  + scale_q16(gain_d, deriv);
            if (total > lim_hi) begin
               x.drive = lim_hi[31:0]; x.clamped = CLAMP_HIGH;
            end else if (total < lim_lo) begin
               x.drive = lim_lo[31:0]; x.clamped = CLAMP_LOW;
            end else begin
               x.drive = total[31:0];
            end
         end
         awaited.push_back(x);
      endfunction

      function void check_result(rsp_type a);
         rsp_type x;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result drive=%h status=%0d clamped=%0d",
                     $time, a.drive, a.status, a.clamped);
            errors++;
            return;
         end
         x = awaited.pop_front();
         if (a.drive !== x.drive) begin
            $display("%0t: drive expected %h actual %h", $time, x.drive, a.drive);
            errors++;
         end
         if (a.status !== x.status) begin
            $display("%0t: status expected %0d actual %0d", $time, x.status, a.status);
            errors++;
         end
         if (a.clamped !== x.clamped) begin
            $display("%0t: clamped expected %0d actual %0d", $time, x.clamped, a.clamped);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   req_type req_data = '0;
   logic rsp_valid, rsp_ready = 0;
   rsp_type rsp_data;
   logic csr_valid = 0, csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   pid_scoreboard board = new();
   bit steady = 0;          // no idling on either side
   bit hold_request = 0;
   logic [31:0] now_us = 32'h1000;

   pid_controller_saturating_core uut (.*);

   always #10 clock = ~clock;

   initial begin
      #(64'd80_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0; hold = 3000;
         end
         if (hold > 0) begin
            hold--; rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 32);
         end
      end
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
   endtask

   task automatic program_regs(logic [31:0] gp, gi, gd, lh, ll);
      write_csr(REG_GAIN_P, gp);
      write_csr(REG_GAIN_I, gi);
      write_csr(REG_GAIN_D, gd);
      write_csr(REG_LIMIT_HIGH, lh);
      write_csr(REG_LIMIT_LOW, ll);
      if ($urandom_range(1)) write_csr(REG_UNUSED, $urandom);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(req_type r);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1; req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(r);
   endtask

   task automatic send_raw(logic [31:0] tgt, meas, stamp);
      req_type r;
      r.target = tgt; r.measured = meas; r.stamp_us = stamp;
      send_sample(r);
   endtask

   // well-formed plant trace mostly, with zero, wrapping and huge intervals
   task automatic send_random;
      req_type r;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) now_us += $urandom_range(2000, 1);
      else if (pick < 80) now_us += 0;
      else if (pick < 88) now_us += $urandom;
      else if (pick < 94) now_us += 1;
      else now_us = $urandom;
      pick = $urandom_range(99);
      if (pick < 75) begin
         r.target = $signed($urandom_range(2000000)) - 1000000;
         r.measured = r.target + $signed($urandom_range(400000)) - 200000;
      end else begin
         r.target = $urandom; r.measured = $urandom;
      end
      r.stamp_us = now_us;
      send_sample(r);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(3))
         0: return $urandom_range(131072);
         1: return -$signed($urandom_range(131072));
         2: return $urandom_range(300);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset registers: everything computes to zero
      repeat (20) send_random();
      drain();

      program_regs(32'sh0001_0000, 32'sh0000_4000, 32'sh0000_0100,
                   32'sh0064_0000, -32'sh0064_0000);
      send_raw(32'h0001_0000, 32'h0002_0000, now_us);
      send_raw(32'h0001_0000, 32'h0002_0000, now_us);
      send_raw(32'h8000_0000, 32'h7FFF_FFFF, now_us + 1);
      send_raw(32'h7FFF_FFFF, 32'h8000_0000, now_us + 2);
      send_raw(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFF0);
      send_raw(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0010);
      send_raw(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_000F);
      repeat (5) send_raw(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_000F + 32'hFFFF_FFFF);
      repeat (5) send_raw(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678 + $urandom);
      send_raw(32'h0000_0000, 32'h0000_0000, 32'h5555_5555);
      send_raw(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      now_us = 32'hAAAA_AAAA;
      drain();

      // extreme gains, tight limits, then limits crossed over
      program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      repeat (150) send_random();
      drain();
      program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   -32'sh0001_0000, 32'sh0001_0000);
      repeat (150) send_random();
      drain();

      // steady stretch, then long receiver hold-off while items keep coming
      program_regs(pick_gain(), pick_gain(), pick_gain(), 32'h7FFF_FFFF, 32'h8000_0000);
      steady = 1;
      repeat (120) send_random();
      steady = 0;
      hold_request = 1;
      repeat (80) send_random();
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         logic [31:0] a, b;
         a = $urandom; b = $urandom;
         if ($signed(a) < $signed(b) || ph == 0)
            program_regs(pick_gain(), pick_gain(), pick_gain(), b, a);
         else
            program_regs(pick_gain(), pick_gain(), pick_gain(), a, b);
         repeat (80) send_random();
         drain();
      end

      repeat (400) @(posedge clock);
      if (board.errors == 0 && board.awaited.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
sv/pidsat_pkg.sv
sv/pidsat_mul.sv
sv/pidsat_div.sv
sv/pid_controller_saturating_core.sv
sim/pid_controller_saturating_core_test.sv
